// File: hw/rtl/rcsq_pkg.sv
// Shared types and constants for the RC stick and switch qualifier.
package rcsq_pkg;

    // Field widths
    localparam int PULSE_W  = 12;
    localparam int STICK_W  = 16;
    localparam int DZ_W     = 8;
    localparam int GAIN_W   = 23;
    localparam int MAG_W    = 12;
    localparam int SAT_W    = 15;
    localparam int NSTICKS  = 4;

    // Stream and configuration port widths
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 72;
    localparam int IN_BITS   = 84;
    localparam int OUT_BITS  = 71;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 23;

    // Fixed pulse-width constants in microseconds and the stick saturation limit
    localparam logic [PULSE_W-1:0] CENTER_US      = 12'd1500;
    localparam logic [PULSE_W-1:0] RANGE_LIMIT_US = 12'd2100;
    localparam logic [SAT_W-1:0]   SAT_MAX        = 15'h7FFF;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STICK_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE_THRESH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GEAR_THRESH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RBT_THRESH  = 3'd4;

    // Register reset values
    localparam logic [DZ_W-1:0]    DEAD_ZONE_RST   = 8'd125;
    localparam logic [GAIN_W-1:0]  STICK_GAIN_RST  = 23'd2863311;
    localparam logic [PULSE_W-1:0] MODE_THRESH_RST = 12'd1750;
    localparam logic [PULSE_W-1:0] GEAR_THRESH_RST = 12'd1750;
    localparam logic [PULSE_W-1:0] RBT_THRESH_RST  = 12'd1500;

    // Switch qualifier flags for one frame
    typedef struct packed {
        logic hover_active;
        logic hover_entered;
        logic command_active;
        logic command_entered;
        logic reboot_pulse;
        logic range_error;
    } sw_flags_t;

endpackage

// File: hw/rtl/rcsq_stick_shaper.sv
// Dead zone, gain and saturation for one stick channel.
module rcsq_stick_shaper (
    input  logic [rcsq_pkg::PULSE_W-1:0]       raw,
    input  logic [rcsq_pkg::DZ_W-1:0]          dz_half,
    input  logic [rcsq_pkg::GAIN_W-1:0]        gain,
    output logic signed [rcsq_pkg::STICK_W-1:0] stick
);
    import rcsq_pkg::*;

    localparam int D_W    = 14;
    localparam int PROD_W = MAG_W + GAIN_W;
    localparam int RND_W  = PROD_W + 1;
    localparam int SCL_W  = RND_W - 16;

    logic signed [D_W-1:0]   diff;
    logic signed [D_W-1:0]   dz_s;
    logic signed [D_W-1:0]   mag_pos;
    logic signed [D_W-1:0]   mag_neg;
    logic                    above;
    logic                    below;
    logic [MAG_W-1:0]        mag;
    logic [PROD_W-1:0]       prod;
    logic [RND_W-1:0]        rnd;
    logic [SCL_W-1:0]        scaled;
    logic [SAT_W-1:0]        sat;
    logic [STICK_W-1:0]      pos_val;

    // Center on 1500 us and strip the dead zone
    always_comb begin
        diff    = $signed({2'b00, raw}) - $signed({2'b00, CENTER_US});
        dz_s    = $signed({{(D_W-DZ_W){1'b0}}, dz_half});
        above   = diff > dz_s;
        below   = diff < -dz_s;
        mag_pos = diff - dz_s;
        mag_neg = -diff - dz_s;
        if (above) begin
            mag = mag_pos[MAG_W-1:0];
        end else if (below) begin
            mag = mag_neg[MAG_W-1:0];
        end else begin
            mag = '0;
        end
    end

    // Scale, round half up on the magnitude, saturate and restore sign
    always_comb begin
        prod    = PROD_W'(mag) * PROD_W'(gain);
        rnd     = RND_W'(prod) + RND_W'(32768);
        scaled  = rnd[RND_W-1:16];
        sat     = (|scaled[SCL_W-1:SAT_W]) ? SAT_MAX : scaled[SAT_W-1:0];
        pos_val = {1'b0, sat};
        stick   = below ? -$signed(pos_val) : $signed(pos_val);
    end

endmodule

// File: hw/rtl/rcsq_switch_logic.sv
// Threshold, edge and mode-gating logic for the mode, gear and reboot switches.
module rcsq_switch_logic (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step,
    input  logic [rcsq_pkg::PULSE_W-1:0] mode,
    input  logic [rcsq_pkg::PULSE_W-1:0] gear,
    input  logic [rcsq_pkg::PULSE_W-1:0] reboot,
    input  logic [rcsq_pkg::PULSE_W-1:0] mode_thresh,
    input  logic [rcsq_pkg::PULSE_W-1:0] gear_thresh,
    input  logic [rcsq_pkg::PULSE_W-1:0] reboot_thresh,
    output rcsq_pkg::sw_flags_t          flags
);
    import rcsq_pkg::*;

    logic               seeded_reg;
    logic [PULSE_W-1:0] prev_mode_reg;
    logic [PULSE_W-1:0] prev_gear_reg;
    logic [PULSE_W-1:0] prev_reboot_reg;
    logic               cmd_level_reg;
    logic               cmd_entry_reg;
    logic               cmd_level_next;
    logic               cmd_entry_next;

    logic [PULSE_W-1:0] pm;
    logic [PULSE_W-1:0] pg;
    logic [PULSE_W-1:0] pr;
    logic               hover;
    logic               gear_rise;
    logic               reboot_rise;

    // First frame sees its own pulses as the previous ones
    always_comb begin
        pm          = seeded_reg ? prev_mode_reg   : mode;
        pg          = seeded_reg ? prev_gear_reg   : gear;
        pr          = seeded_reg ? prev_reboot_reg : reboot;
        hover       = mode > mode_thresh;
        gear_rise   = (pg < gear_thresh) && (gear > gear_thresh);
        reboot_rise = (pr < reboot_thresh) && (reboot > reboot_thresh);
    end

    // Command mode follows gear only while hover is on
    always_comb begin
        cmd_level_next = cmd_level_reg;
        cmd_entry_next = cmd_entry_reg;
        if (hover) begin
            if (gear_rise) begin
                cmd_entry_next = 1'b1;
            end else if (gear < gear_thresh) begin
                cmd_entry_next = 1'b0;
            end
            cmd_level_next = gear > gear_thresh;
        end
    end

    // Flags for this frame
    always_comb begin
        flags.hover_active    = hover;
        flags.hover_entered   = (pm < mode_thresh) && hover;
        flags.command_active  = cmd_level_next;
        flags.command_entered = cmd_entry_next;
        flags.reboot_pulse    = !hover && !cmd_level_next && reboot_rise;
        flags.range_error     = (mode > RANGE_LIMIT_US) || (gear > RANGE_LIMIT_US) ||
                                (reboot > RANGE_LIMIT_US);
    end

    // Advance switch history on each processed frame
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seeded_reg      <= 1'b0;
            prev_mode_reg   <= '0;
            prev_gear_reg   <= '0;
            prev_reboot_reg <= '0;
            cmd_level_reg   <= 1'b1;
            cmd_entry_reg   <= 1'b0;
        end else if (step) begin
            seeded_reg      <= 1'b1;
            prev_mode_reg   <= mode;
            prev_gear_reg   <= gear;
            prev_reboot_reg <= reboot;
            cmd_level_reg   <= cmd_level_next;
            cmd_entry_reg   <= cmd_entry_next;
        end
    end

`ifndef SYNTHESIS
    // No edge can be reported on the seeding frame
    a_no_edge_first: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !seeded_reg |-> !flags.hover_entered && !flags.reboot_pulse)
        else $error("edge flagged on first frame");

    // Command state holds while hover is off
    a_cmd_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !flags.hover_active |=>
            cmd_level_reg == $past(cmd_level_reg) && cmd_entry_reg == $past(cmd_entry_reg))
        else $error("command state changed outside hover");

    // History only moves on a processed frame
    a_hist_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(prev_mode_reg) && $stable(seeded_reg) && $stable(cmd_level_reg))
        else $error("switch history changed without a frame");
`endif

endmodule

// File: hw/rtl/rc_stick_and_switch_qualifier.sv
// Top level of the RC stick and switch qualifier: stream ports, registers, staging.
//
//  channel  | direction | width        | contents
//  ---------+-----------+--------------+-----------------------------------------
//  s_*      | in        | 88 tdata     | one RC frame, seven 12 bit pulse widths
//  m_*      | out       | 72 tdata     | four Q2.14 sticks and seven flags
//  cfg_*    | in        | 3 idx/23 dat | register writes, always ready
//
//  A frame's input transfer loads the input register; the stick multipliers and
//  switch logic then load it into the result register once that register is free
//  or drained. One frame is accepted per cycle while m_tready stays high. A stall
//  on m_* holds the result register; the input register keeps taking a frame
//  until both stages are full. aresetn is synchronous and active low.
module rc_stick_and_switch_qualifier (
    input  logic                                aclk,
    input  logic                                aresetn,
    // stick_raw_0, stick_raw_1, stick_raw_2, stick_raw_3, mode_raw, gear_raw,
    // reboot_raw (12 bits each, from bit 0 up), 4 zero pad bits
    input  logic [rcsq_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // stick_out_0, stick_out_1, stick_out_2, stick_out_3 (16 bits each),
    // hover_active, hover_entered, command_active, command_entered,
    // reboot_pulse, sticks_centered, range_error, 1 zero pad bit
    output logic [rcsq_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rcsq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rcsq_pkg::CFG_DAT_W-1:0]      cfg_data
);
    import rcsq_pkg::*;

    logic [DZ_W-1:0]    dz_half_reg;
    logic [GAIN_W-1:0]  stick_gain_reg;
    logic [PULSE_W-1:0] mode_thresh_reg;
    logic [PULSE_W-1:0] gear_thresh_reg;
    logic [PULSE_W-1:0] rbt_thresh_reg;

    logic                in_valid_reg;
    logic                in_valid_next;
    logic [IN_BITS-1:0]  in_data_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [OUT_BITS-1:0] out_data_reg;
    logic [OUT_BITS-1:0] out_data_next;

    logic                advance;
    logic                fire;
    logic signed [STICK_W-1:0] stick [NSTICKS];
    sw_flags_t           flags;
    logic                centered;

    // Configuration writes are taken every cycle
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dz_half_reg     <= DEAD_ZONE_RST;
            stick_gain_reg  <= STICK_GAIN_RST;
            mode_thresh_reg <= MODE_THRESH_RST;
            gear_thresh_reg <= GEAR_THRESH_RST;
            rbt_thresh_reg  <= RBT_THRESH_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_DEAD_ZONE:   dz_half_reg     <= cfg_data[DZ_W-1:0];
                REG_STICK_GAIN:  stick_gain_reg  <= cfg_data[GAIN_W-1:0];
                REG_MODE_THRESH: mode_thresh_reg <= cfg_data[PULSE_W-1:0];
                REG_GEAR_THRESH: gear_thresh_reg <= cfg_data[PULSE_W-1:0];
                REG_RBT_THRESH:  rbt_thresh_reg  <= cfg_data[PULSE_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline handshake: advance when the result register is free or drained
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the frame on an input transfer
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata[IN_BITS-1:0];
        end
    end

    // Stick channels
    for (genvar i = 0; i < NSTICKS; i++) begin : g_stick
        rcsq_stick_shaper u_shaper (
            .raw       (in_data_reg[i*PULSE_W +: PULSE_W]),
            .dz_half   (dz_half_reg),
            .gain      (stick_gain_reg),
            .stick     (stick[i])
        );
    end

    // Switch channels
    rcsq_switch_logic u_switch (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (fire),
        .mode          (in_data_reg[4*PULSE_W +: PULSE_W]),
        .gear          (in_data_reg[5*PULSE_W +: PULSE_W]),
        .reboot        (in_data_reg[6*PULSE_W +: PULSE_W]),
        .mode_thresh   (mode_thresh_reg),
        .gear_thresh   (gear_thresh_reg),
        .reboot_thresh (rbt_thresh_reg),
        .flags         (flags)
    );

    // Pack the result
    always_comb begin
        centered = (stick[0] == '0) && (stick[1] == '0) &&
                   (stick[2] == '0) && (stick[3] == '0);
        out_data_next = {flags.range_error, centered, flags.reboot_pulse,
                         flags.command_entered, flags.command_active,
                         flags.hover_entered, flags.hover_active,
                         stick[3], stick[2], stick[1], stick[0]};
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-OUT_BITS){1'b0}}, out_data_reg};

`ifndef SYNTHESIS
    // Centered flag agrees with the stick values it travels with
    a_centered: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_data_reg[69] == (out_data_reg[63:0] == 64'd0))
        else $error("sticks_centered disagrees with stick outputs");

    // A held input frame is never dropped while the result stage is stalled
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_data_reg))
        else $error("input frame lost during stall");

    // A stalled result keeps its data until the transfer
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
`endif

endmodule

// File: tb/sv/rcsq_tb_pkg.sv
// Frame and result types plus the expected-result scoreboard for the RC qualifier bench.
`timescale 1ns / 1ps

package rcsq_tb_pkg;

    import rcsq_pkg::*;

    // One RC frame as packed on s_tdata, lowest field first
    typedef struct packed {
        logic [PULSE_W-1:0]                reboot;
        logic [PULSE_W-1:0]                gear;
        logic [PULSE_W-1:0]                mode;
        logic [NSTICKS-1:0][PULSE_W-1:0]   stick;
    } frame_t;

    // Flag positions above the four sticks in m_tdata
    typedef enum int {
        HOVER_ACTIVE,
        HOVER_ENTERED,
        COMMAND_ACTIVE,
        COMMAND_ENTERED,
        REBOOT_PULSE,
        STICKS_CENTERED,
        RANGE_ERROR
    } result_flag_e;

    typedef struct packed {
        logic [6:0]                        flags;
        logic [NSTICKS-1:0][STICK_W-1:0]   stick;
    } stick_result_t;

    localparam int REPORT_CAP = 100;

    class frame_scoreboard;

        // register copy
        logic [DZ_W-1:0]    dz_half;
        logic [GAIN_W-1:0]  gain;
        logic [PULSE_W-1:0] mode_thr;
        logic [PULSE_W-1:0] gear_thr;
        logic [PULSE_W-1:0] reboot_thr;

        // switch history
        bit                 seeded;
        logic [PULSE_W-1:0] hist_mode;
        logic [PULSE_W-1:0] hist_gear;
        logic [PULSE_W-1:0] hist_reboot;
        bit                 command_level;
        bit                 command_entry;

        stick_result_t      pending_results[$];

        int errors;
        int frames_in;
        int results_out;
        int hover_entries;
        int command_entries;
        int reboot_pulses;
        int saturated;
        int range_errors;

        function new();
            dz_half       = DEAD_ZONE_RST;
            gain          = STICK_GAIN_RST;
            mode_thr      = MODE_THRESH_RST;
            gear_thr      = GEAR_THRESH_RST;
            reboot_thr    = RBT_THRESH_RST;
            seeded        = 0;
            hist_mode     = '0;
            hist_gear     = '0;
            hist_reboot   = '0;
            command_level = 1;
            command_entry = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Mirror a register write; unmapped indexes and upper data bits drop out
        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                REG_DEAD_ZONE:   dz_half    = data[DZ_W-1:0];
                REG_STICK_GAIN:  gain       = data[GAIN_W-1:0];
                REG_MODE_THRESH: mode_thr   = data[PULSE_W-1:0];
                REG_GEAR_THRESH: gear_thr   = data[PULSE_W-1:0];
                REG_RBT_THRESH:  reboot_thr = data[PULSE_W-1:0];
                default: ;
            endcase
        endfunction

        // Dead zone, gain with round half away from zero, saturate, restore sign
        function logic [STICK_W-1:0] shape_stick(logic [PULSE_W-1:0] raw);
            int          offset;
            int          dz;
            int          excess;
            logic [63:0] mag;
            offset = int'(raw) - int'(CENTER_US);
            dz     = int'(dz_half);
            if (offset > dz)
                excess = offset - dz;
            else if (offset < -dz)
                excess = offset + dz;
            else
                excess = 0;
            mag = (excess < 0) ? -excess : excess;
            mag = (mag * gain + 64'd32768) >> 16;
            if (mag > 64'd32767) begin
                mag = 64'd32767;
                saturated++;
            end
            if (excess < 0)
                return 16'h0000 - mag[STICK_W-1:0];
            return mag[STICK_W-1:0];
        endfunction

        function bit crossed_up(logic [PULSE_W-1:0] prev, logic [PULSE_W-1:0] cur,
                                logic [PULSE_W-1:0] thr);
            return prev < thr && cur > thr;
        endfunction

        // Work out the result of an accepted frame and queue it
        function void note_frame(frame_t f);
            stick_result_t want;
            bit            hover;
            want = '0;
            want.flags[STICKS_CENTERED] = 1'b1;
            for (int i = 0; i < NSTICKS; i++) begin
                want.stick[i] = shape_stick(f.stick[i]);
                if (want.stick[i] != '0)
                    want.flags[STICKS_CENTERED] = 1'b0;
            end
            want.flags[RANGE_ERROR] = f.mode > RANGE_LIMIT_US || f.gear > RANGE_LIMIT_US ||
                                      f.reboot > RANGE_LIMIT_US;

            // first frame only seeds the history
            if (!seeded) begin
                seeded      = 1;
                hist_mode   = f.mode;
                hist_gear   = f.gear;
                hist_reboot = f.reboot;
            end

            want.flags[HOVER_ENTERED] = crossed_up(hist_mode, f.mode, mode_thr);
            hover = f.mode > mode_thr;

            // gear follows only while hover is on, held otherwise
            if (hover) begin
                if (crossed_up(hist_gear, f.gear, gear_thr))
                    command_entry = 1;
                else if (f.gear < gear_thr)
                    command_entry = 0;
                command_level = f.gear > gear_thr;
            end

            want.flags[REBOOT_PULSE] = !hover && !command_level &&
                                       crossed_up(hist_reboot, f.reboot, reboot_thr);
            hist_mode   = f.mode;
            hist_gear   = f.gear;
            hist_reboot = f.reboot;

            want.flags[HOVER_ACTIVE]    = hover;
            want.flags[COMMAND_ACTIVE]  = command_level;
            want.flags[COMMAND_ENTERED] = command_entry;

            hover_entries   += want.flags[HOVER_ENTERED];
            command_entries += want.flags[COMMAND_ENTERED];
            reboot_pulses   += want.flags[REBOOT_PULSE];
            range_errors    += want.flags[RANGE_ERROR];
            frames_in++;
            pending_results.push_back(want);
        endfunction

        // Compare one result transfer with the oldest expectation
        function void check_result(logic [OUT_BITS-1:0] word);
            stick_result_t got;
            stick_result_t want;
            result_flag_e  flag_id;
            got = word;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: result with nothing expected, actual %h", $time, word);
                return;
            end
            want = pending_results.pop_front();
            results_out++;
            for (int i = 0; i < NSTICKS; i++) begin
                if (got.stick[i] !== want.stick[i]) begin
                    errors++;
                    if (errors <= REPORT_CAP)
                        $display("%0t: result %0d stick_out_%0d expected %0d actual %0d",
                                 $time, results_out, i, $signed(want.stick[i]),
                                 $signed(got.stick[i]));
                end
            end
            for (int i = 0; i <= RANGE_ERROR; i++) begin
                if (got.flags[i] !== want.flags[i]) begin
                    errors++;
                    flag_id = result_flag_e'(i);
                    if (errors <= REPORT_CAP)
                        $display("%0t: result %0d %s expected %b actual %b", $time,
                                 results_out, flag_id.name(), want.flags[i],
                                 got.flags[i]);
                end
            end
        endfunction

    endclass

endpackage

// File: tb/sv/testbench.sv
// Top of the RC stick and switch qualifier bench: clock, reset, stream drivers and checks.
`timescale 1ns / 1ps

module testbench;

    import rcsq_pkg::*;
    import rcsq_tb_pkg::*;

    localparam int NUM_PHASES   = 8;
    localparam int PHASE_FRAMES = 204;
    localparam int QUIET_LIMIT  = 4000;
    localparam int LONG_HOLD    = 300;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    logic                  aclk;
    logic                  aresetn;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DAT_W-1:0]  cfg_data;

    frame_scoreboard frames = new();

    bit     tx_quiet;
    bit     rx_quiet;
    int     rx_hold;
    int     long_holds;
    int     settings;
    int     quiet_cycles;
    frame_t last_frame;

    rc_stick_and_switch_qualifier uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Check every result transfer
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            frames.check_result(m_tdata[OUT_BITS-1:0]);
    end

    // End the run when no transfer happens for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results still expected",
                         $time, QUIET_LIMIT, frames.pending());
                $display("[rc_stick_and_switch_qualifier] ERROR");
                $finish;
            end
        end
    end

    // Result side: random stalls, bursts with none, and one long hold-off
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (rx_hold > 0) begin
                stall = rx_hold;
                rx_hold = 0;
                long_holds++;
            end else begin
                stall = rx_quiet ? 0 : $urandom_range(0, 16);
            end
            repeat (stall) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    function automatic logic [PULSE_W-1:0] clamp_pulse(int v);
        if (v < 0)
            return '0;
        if (v > 4095)
            return 12'hFFF;
        return v[PULSE_W-1:0];
    endfunction

    // Switch pulse biased around its threshold and the range limit
    function automatic logic [PULSE_W-1:0] pick_switch(logic [PULSE_W-1:0] thr);
        int t;
        t = int'(thr);
        case ($urandom_range(0, 9))
            0, 1:    return clamp_pulse(t - 1 - int'($urandom_range(0, 400)));
            2:       return thr;
            3, 4, 5: return clamp_pulse(t + 1 + int'($urandom_range(0, 400)));
            6:       return clamp_pulse(int'(RANGE_LIMIT_US) - 2 + int'($urandom_range(0, 4)));
            7:       return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            default: return PULSE_W'($urandom_range(0, 4095));
        endcase
    endfunction

    // Stick pulse biased around the dead zone edges
    function automatic logic [PULSE_W-1:0] pick_stick(logic [DZ_W-1:0] dz);
        int mag;
        mag = int'(dz);
        case ($urandom_range(0, 7))
            0:       mag = mag - 1 + int'($urandom_range(0, 2));
            1:       mag = 0;
            2:       return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            3, 4:    return PULSE_W'($urandom_range(1000, 2000));
            5:       mag = mag + int'($urandom_range(0, 600));
            default: return PULSE_W'($urandom_range(0, 4095));
        endcase
        return clamp_pulse($urandom_range(0, 1) ? int'(CENTER_US) + mag
                                                : int'(CENTER_US) - mag);
    endfunction

    // Switches stay put a third of the time so levels are held across frames
    function automatic frame_t random_frame();
        frame_t f;
        for (int i = 0; i < NSTICKS; i++)
            f.stick[i] = pick_stick(frames.dz_half);
        f.mode   = ($urandom_range(0, 2) == 0) ? last_frame.mode
                                                : pick_switch(frames.mode_thr);
        f.gear   = ($urandom_range(0, 2) == 0) ? last_frame.gear
                                                : pick_switch(frames.gear_thr);
        f.reboot = ($urandom_range(0, 2) == 0) ? last_frame.reboot
                                                : pick_switch(frames.reboot_thr);
        return f;
    endfunction

    function automatic frame_t make_frame(int s0, int s1, int s2, int s3,
                                          int mode, int gear, int reboot);
        frame_t f;
        f.stick[0] = PULSE_W'(s0);
        f.stick[1] = PULSE_W'(s1);
        f.stick[2] = PULSE_W'(s2);
        f.stick[3] = PULSE_W'(s3);
        f.mode     = PULSE_W'(mode);
        f.gear     = PULSE_W'(gear);
        f.reboot   = PULSE_W'(reboot);
        return f;
    endfunction

    // Offer one frame after a random gap and hold it until the transfer
    task automatic send_frame(frame_t f);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 16);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tdata  <= {{(S_TDATA_W - IN_BITS){1'b0}}, f};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        frames.note_frame(f);
        last_frame = f;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        frames.set_reg(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait for every expected result, then let the pipeline settle
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (frames.pending() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic configure(int phase);
        logic [CFG_DAT_W-1:0] dz;
        logic [CFG_DAT_W-1:0] gain;
        logic [CFG_DAT_W-1:0] mode_t;
        logic [CFG_DAT_W-1:0] gear_t;
        logic [CFG_DAT_W-1:0] rbt_t;
        case (phase)
            0: begin
                dz = 0; gain = 4294967; mode_t = 0; gear_t = 0; rbt_t = 0;
            end
            1: begin
                dz = 255; gain = 23'h7FFFFF; mode_t = 4095; gear_t = 4095; rbt_t = 4095;
            end
            2: begin
                dz = 250; gain = 4294967; mode_t = 1500; gear_t = 1200; rbt_t = 1800;
            end
            3: begin
                dz = 0; gain = 0; mode_t = 1750; gear_t = 1750; rbt_t = 1500;
            end
            4: begin
                // reset values with junk above each register's width
                dz     = 23'h7FFF00 | 125;
                gain   = 2863311;
                mode_t = 23'h7FF000 | 1750;
                gear_t = 23'h555000 | 1750;
                rbt_t  = 23'h2AA000 | 1500;
            end
            default: begin
                dz     = CFG_DAT_W'(($urandom_range(0, 7) == 0) ? 255
                                                                 : $urandom_range(0, 250));
                gain   = $urandom_range(0, 1)
                             ? CFG_DAT_W'((32'd1 << 30) / (32'd500 - 32'(dz)))
                             : CFG_DAT_W'($urandom_range(0, 23'h7FFFFF));
                mode_t = CFG_DAT_W'($urandom_range(900, 2200));
                gear_t = CFG_DAT_W'($urandom_range(900, 2200));
                rbt_t  = CFG_DAT_W'($urandom_range(900, 2200));
            end
        endcase
        write_reg(REG_DEAD_ZONE, dz);
        write_reg(REG_STICK_GAIN, gain);
        write_reg(REG_MODE_THRESH, mode_t);
        write_reg(REG_GEAR_THRESH, gear_t);
        write_reg(REG_RBT_THRESH, rbt_t);
        if (phase == 0)
            write_reg(REG_UNMAPPED, 23'h7FFFFF);
        settings++;
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tdata   = '0;
        s_tvalid  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        tx_quiet  = 0;
        rx_quiet  = 0;
        rx_hold   = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed frames at reset settings: seeding, equal thresholds, gating, extremes
        send_frame(make_frame(1500, 1500, 1500, 1500, 2000, 2000, 2000));
        send_frame(make_frame(1625, 1626, 1374, 1375, 1000, 1000, 1000));
        send_frame(make_frame(0, 4095, 1376, 1624, 2200, 1000, 1000));
        send_frame(make_frame(1500, 1500, 1500, 1500, 2200, 1750, 1000));
        send_frame(make_frame(1500, 1500, 1500, 1500, 2200, 1800, 1000));
        send_frame(make_frame(1500, 1500, 1500, 1500, 2200, 1000, 1000));
        send_frame(make_frame(1500, 1500, 1500, 1500, 2200, 1751, 1000));
        send_frame(make_frame(1500, 1500, 1500, 1500, 1750, 1000, 1000));
        send_frame(make_frame(1500, 1500, 1500, 1500, 1751, 1000, 1000));
        send_frame(make_frame(1500, 1500, 1500, 1500, 1000, 1000, 1000));
        send_frame(make_frame(1500, 1500, 1500, 1500, 1000, 1000, 1501));
        send_frame(make_frame(1500, 1500, 1500, 1500, 1000, 1000, 1500));
        send_frame(make_frame(1500, 1500, 1500, 1500, 1000, 1000, 1600));
        send_frame(make_frame(1500, 1500, 1500, 1500, 1000, 1000, 1000));
        send_frame(make_frame(1500, 1500, 1500, 1500, 2000, 1000, 1600));
        send_frame(make_frame(1500, 1500, 1500, 1500, 2000, 2000, 1000));
        send_frame(make_frame(1500, 1500, 1500, 1500, 1000, 1000, 1600));
        send_frame(make_frame(4095, 0, 4095, 0, 4095, 4095, 4095));
        send_frame(make_frame(0, 0, 0, 0, 0, 0, 0));
        send_frame(make_frame(1500, 1500, 1500, 1500, 2100, 2101, 2100));
        send_frame(make_frame(1500, 1500, 1500, 1500, 2101, 2100, 2100));
        send_frame(make_frame(1500, 1500, 1500, 1500, 2100, 2100, 2101));

        // Random frames under a series of register settings
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            configure(p);
            for (int n = 0; n < PHASE_FRAMES; n++) begin
                if (n % 32 == 0) begin
                    tx_quiet = ($urandom_range(0, 3) == 0);
                    rx_quiet = ($urandom_range(0, 3) == 0);
                    // back up the result side while frames keep coming
                    if (p == 2 && n == 0) begin
                        tx_quiet = 1;
                        rx_hold  = LONG_HOLD;
                    end
                end
                send_frame(random_frame());
            end
        end

        drain_results();
        repeat (8) @(posedge aclk);
        $display("Ran %0d frames over %0d register settings, %0d results checked, %0d long stalls",
                 frames.frames_in, settings + 1, frames.results_out, long_holds);
        $display("Saw %0d hover entries, %0d command entries, %0d reboot pulses,",
                 frames.hover_entries, frames.command_entries, frames.reboot_pulses);
        $display("    %0d range errors, %0d saturated sticks",
                 frames.range_errors, frames.saturated);
        if (frames.errors == 0 && frames.pending() == 0) begin
            $display("[rc_stick_and_switch_qualifier] OK");
        end else begin
            $display("%0d mismatches, %0d results missing", frames.errors, frames.pending());
            $display("[rc_stick_and_switch_qualifier] ERROR");
        end
        $finish;
    end

endmodule

// File: rc_stick_and_switch_qualifier.f
hw/rtl/rcsq_pkg.sv
hw/rtl/rcsq_stick_shaper.sv
hw/rtl/rcsq_switch_logic.sv
hw/rtl/rc_stick_and_switch_qualifier.sv
tb/sv/rcsq_tb_pkg.sv
tb/sv/testbench.sv
